@@ rtl/y420rgb_pkg.sv @@
// shared constants, types and helper functions for the ycbcr 4:2:0 to rgb565 converter
package y420rgb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int PIXEL_W  = 16;
    localparam int ACC_W    = 16;
    localparam int FRAC_W   = 5;

    localparam int S_DATA_W = 6 * SAMPLE_W;

    // fixed point coefficients, 5 fractional bits
    localparam logic signed [ACC_W-1:0] COEF_CB_B = 16'sd57;
    localparam logic signed [ACC_W-1:0] COEF_CB_G = 16'sd11;
    localparam logic signed [ACC_W-1:0] COEF_CR_G = 16'sd23;
    localparam logic signed [ACC_W-1:0] COEF_CR_R = 16'sd45;
    localparam logic [ACC_W-1:0]        LUMA_BIAS = 16'd16;
    localparam logic [9:0]              AVG_ROUND = 10'd2;

    typedef enum logic {
        SCALE_1TO1 = 1'b0,
        SCALE_1TO2 = 1'b1
    } scale_mode_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] chroma_red;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] luma_bottom_right;
        logic [SAMPLE_W-1:0] luma_bottom_left;
        logic [SAMPLE_W-1:0] luma_top_right;
        logic [SAMPLE_W-1:0] luma_top_left;
    } sample_word_t;

    // drop the fraction and clamp to 0..255
    function automatic logic [7:0] chan_sat(input logic signed [ACC_W-1:0] acc);
        logic [7:0] res;
        if (acc[ACC_W-1]) begin
            res = 8'd0;
        end else if (acc[ACC_W-2:FRAC_W+8] != '0) begin
            res = 8'hFF;
        end else begin
            res = acc[FRAC_W+7:FRAC_W];
        end
        return res;
    endfunction

endpackage

@@ rtl/y420rgb_convert.sv @@
// combinational luma select/average and color conversion of one word
module y420rgb_convert
    import y420rgb_pkg::*;
(
    input  sample_word_t       samples,
    input  scale_mode_t        scale_mode,
    output logic [PIXEL_W-1:0] pixel_rgb565
);

    logic [9:0]              luma_sum;
    logic [SAMPLE_W-1:0]     luma;
    logic signed [ACC_W-1:0] yy;
    logic signed [ACC_W-1:0] u;
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] acc_b;
    logic signed [ACC_W-1:0] acc_g;
    logic signed [ACC_W-1:0] acc_r;
    logic [7:0]              chan_b;
    logic [7:0]              chan_g;
    logic [7:0]              chan_r;

    always_comb begin
        luma_sum = 10'(samples.luma_top_left) + 10'(samples.luma_top_right)
                 + 10'(samples.luma_bottom_left) + 10'(samples.luma_bottom_right)
                 + AVG_ROUND;
        case (scale_mode)
            SCALE_1TO2: luma = luma_sum[9:2];
            default:    luma = samples.luma_top_left;
        endcase
    end

    // subtracting 128 from an 8-bit sample is an msb flip into two's complement
    assign u = ACC_W'($signed({~samples.chroma_blue[7], samples.chroma_blue[6:0]}));
    assign v = ACC_W'($signed({~samples.chroma_red[7], samples.chroma_red[6:0]}));

    assign yy    = $signed({3'b000, luma, 5'b00000} | LUMA_BIAS);
    assign acc_b = yy + COEF_CB_B * u;
    assign acc_g = yy - COEF_CB_G * u - COEF_CR_G * v;
    assign acc_r = yy + COEF_CR_R * v;

    assign chan_b = chan_sat(acc_b);
    assign chan_g = chan_sat(acc_g);
    assign chan_r = chan_sat(acc_r);

    assign pixel_rgb565 = {chan_r[7:3], chan_g[7:2], chan_b[7:3]};

endmodule

@@ rtl/ycbcr420_to_rgb565_scaler.sv @@
// top level: ycbcr 4:2:0 square to rgb565 pixel stream with optional 2x2 luma averaging
//
// Takes one word per clock: four luma samples of a 2x2 square plus the shared Cb/Cr pair,
// and returns one RGB565 pixel per word. The word is captured in an input register, the
// luma selection or rounded average and the fixed point color conversion run in one
// combinational pass, and the pixel lands in an output register that drives m_tvalid;
// throughput is one pixel per clock when m_tready stays high. scale_mode (written on the
// cfg channel, always ready) picks 1:1 (top-left luma only) or 1:2 (average of all four);
// change it only while no words are in flight.
module ycbcr420_to_rgb565_scaler
    import y420rgb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red (8 bits each, lowest first)
    input  logic [S_DATA_W-1:0] s_tdata,

    output logic                m_tvalid,
    input  logic                m_tready,
    // pixel_rgb565
    output logic [PIXEL_W-1:0]  m_tdata,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    scale_mode_t        scale_mode_reg;
    logic               in_valid_reg;
    sample_word_t       in_word_reg;
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic [PIXEL_W-1:0] pixel_next;
    logic               out_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_mode_reg <= SCALE_1TO1;
        end else if (cfg_valid) begin
            scale_mode_reg <= scale_mode_t'(cfg_data);
        end
    end

    // input stage moves on when the output register is free or being drained
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_word_reg <= sample_word_t'(s_tdata);
        end
    end

    y420rgb_convert u_convert (
        .samples      (in_word_reg),
        .scale_mode   (scale_mode_reg),
        .pixel_rgb565 (pixel_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && in_valid_reg) begin
            out_pixel_reg <= pixel_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;

    a_accept_fills_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted word did not reach the input register");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg && $stable(in_word_reg))
        else $error("input register changed while the output was stalled");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |=> scale_mode_reg == scale_mode_t'($past(cfg_data)))
        else $error("scale mode write not taken");

    a_pipe_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("word lost between input and output registers");

endmodule

@@ verif/rgb565_pixel_checker.sv @@
// pixel checker for the ycbcr 4:2:0 to rgb565 converter: tracks scale mode, predicts and compares
module rgb565_pixel_checker
    import y420rgb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [PIXEL_W-1:0]  m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,
    output int                  fail_count,
    output int                  pending_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    scale_mode_t        scale_reg;
    logic [PIXEL_W-1:0] expected_pixels[$];

    // drop the 5 fraction bits and clamp to 0..255
    function automatic logic [7:0] clamp_channel(input int acc);
        if (acc < 0) begin
            return 8'd0;
        end
        if ((acc >>> 5) > 255) begin
            return 8'hFF;
        end
        return 8'(acc >>> 5);
    endfunction

    function automatic logic [PIXEL_W-1:0] predict_pixel(input sample_word_t w,
                                                         input scale_mode_t mode);
        int luma;
        int yy;
        int u;
        int v;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        if (mode == SCALE_1TO2) begin
            luma = (int'(w.luma_top_left) + int'(w.luma_top_right) +
                    int'(w.luma_bottom_left) + int'(w.luma_bottom_right) + 2) >> 2;
        end else begin
            luma = int'(w.luma_top_left);
        end
        yy = luma * 32 + 16;
        u  = int'(w.chroma_blue) - 128;
        v  = int'(w.chroma_red) - 128;
        b  = clamp_channel(yy + 57 * u);
        g  = clamp_channel(yy - 11 * u - 23 * v);
        r  = clamp_channel(yy + 45 * v);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    task automatic report(input string what, input logic [PIXEL_W-1:0] got,
                          input logic [PIXEL_W-1:0] want);
        $display("checker @%0t: %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        logic [PIXEL_W-1:0] want;
        if (!aresetn) begin
            scale_reg  = SCALE_1TO1;
            fail_count = 0;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report("pixel with no word pending", m_tdata, '0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want) begin
                        report("pixel_rgb565 mismatch", m_tdata, want);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(predict_pixel(sample_word_t'(s_tdata), scale_reg));
            end
            if (cfg_valid && cfg_ready) begin
                scale_reg = scale_mode_t'(cfg_data);
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

@@ verif/ycbcr420_to_rgb565_scaler_tb.sv @@
// testbench top for the ycbcr 4:2:0 to rgb565 converter: clock, reset, stimulus and verdict
module ycbcr420_to_rgb565_scaler_tb
    import y420rgb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_CHUNKS = 10;
    localparam int CHUNK_WORDS   = 115;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_CHUNK    = 3;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [PIXEL_W-1:0]  m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_data;

    int mismatches;
    int pending_pixels;
    int tx_gap_pct;
    int rx_stall_pct;
    bit long_hold_req;

    ycbcr420_to_rgb565_scaler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rgb565_pixel_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (mismatches),
        .pending_pixels (pending_pixels)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // pixel sink: random stall bursts plus one long hold on request
    initial begin
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (long_hold_req && !hold_done) begin
                hold_done  = 1'b1;
                m_tready   = 1'b0;
                stall_left = LONG_HOLD - 1;
            end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 17);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic write_scale(input scale_mode_t mode);
        cfg_valid = 1'b1;
        cfg_data  = mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // s_tvalid stays high after a word so back-to-back words need no toggle
    task automatic send_square(input sample_word_t w);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic [7:0] tl, input logic [7:0] tr,
                               input logic [7:0] bl, input logic [7:0] br,
                               input logic [7:0] cb, input logic [7:0] cr);
        sample_word_t w;
        w.luma_top_left     = tl;
        w.luma_top_right    = tr;
        w.luma_bottom_left  = bl;
        w.luma_bottom_right = br;
        w.chroma_blue       = cb;
        w.chroma_red        = cr;
        send_square(w);
    endtask

    // wait until every predicted pixel has come out
    task automatic drain_pixels();
        s_tvalid = 1'b0;
        while (pending_pixels != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    // leans on the extremes so saturation and rounding edges come up often
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(0, 24));
            3:       return 8'($urandom_range(231, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    initial begin
        sample_word_t w;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        long_hold_req = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // 1:1 mode: only top-left luma matters, chroma drives each channel into clamp
        write_scale(SCALE_1TO1);
        send_fields(8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128);
        send_fields(8'd255, 8'd0,   8'd0,   8'd0,   8'd128, 8'd128);
        send_fields(8'd0,   8'd255, 8'd255, 8'd255, 8'd128, 8'd128);
        send_fields(8'd128, 8'd0,   8'd0,   8'd0,   8'd0,   8'd128);
        send_fields(8'd128, 8'd0,   8'd0,   8'd0,   8'd255, 8'd128);
        send_fields(8'd128, 8'd0,   8'd0,   8'd0,   8'd128, 8'd0);
        send_fields(8'd128, 8'd0,   8'd0,   8'd0,   8'd128, 8'd255);
        send_fields(8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd255);
        send_fields(8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd0);
        send_fields(8'd0,   8'd77,  8'd200, 8'd13,  8'd0,   8'd0);
        send_fields(8'd255, 8'd1,   8'd2,   8'd3,   8'd255, 8'd255);
        drain_pixels();

        // 1:2 mode: rounding of the four-sample average
        write_scale(SCALE_1TO2);
        send_fields(8'd0,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128);
        send_fields(8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128);
        send_fields(8'd1,   8'd0,   8'd0,   8'd0,   8'd128, 8'd128);
        send_fields(8'd1,   8'd1,   8'd0,   8'd0,   8'd128, 8'd128);
        send_fields(8'd1,   8'd1,   8'd1,   8'd0,   8'd128, 8'd128);
        send_fields(8'd255, 8'd254, 8'd254, 8'd254, 8'd128, 8'd128);
        send_fields(8'd255, 8'd255, 8'd255, 8'd254, 8'd128, 8'd128);
        send_fields(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255);
        send_fields(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
        send_fields(8'd200, 8'd10,  8'd90,  8'd31,  8'd60,  8'd200);
        drain_pixels();

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            write_scale(chunk % 2 == 0 ? SCALE_1TO1 : SCALE_1TO2);
            if (chunk == RANDOM_CHUNKS - 1) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = pick_idle_pct();
                rx_stall_pct = pick_idle_pct();
            end
            // sink holds off while the source keeps offering, so the pipe backs up
            if (chunk == HOLD_CHUNK) begin
                long_hold_req = 1'b1;
            end
            repeat (CHUNK_WORDS) begin
                w.luma_top_left     = pick_sample();
                w.luma_top_right    = pick_sample();
                w.luma_bottom_left  = pick_sample();
                w.luma_bottom_right = pick_sample();
                w.chroma_blue       = pick_sample();
                w.chroma_red        = pick_sample();
                send_square(w);
            end
            drain_pixels();
        end

        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
